### design/tep_pkg.sv
package tep_pkg;

	localparam int WORD_W = 64;
	localparam int SEC_W  = 41;
	localparam int TICK_W = 27;
	localparam int FRAC_W = 12;

	// running sums, one per scale; picosecond weights are applied at end of text
	typedef struct packed {
		logic [WORD_W-1:0] ps;
		logic [WORD_W-1:0] ns;
		logic [WORD_W-1:0] us;
		logic [WORD_W-1:0] ms;
		logic [WORD_W-1:0] sec;
	} sums_t;

	// handshake between the character stage and the end-of-text pipeline
	typedef struct packed {
		logic adv;
		logic load;
		logic err;
	} norm_ctl_t;

endpackage

### design/time_expression_parser_core.sv
// channel | signals                                   | handshake
// in      | char_code, end_of_text                    | in_valid / in_ready
// out     | seconds, coarse_ticks, fraction, parse_error | out_valid / out_ready
//
// One character is taken per cycle while in_ready is high; the running term and sums update at the accepting edge.
// An end-of-text item gives its result once it has passed the registered stages of the
// end-of-text pipeline (sum weighting, divide by 1e12, divide by 8000).
// Items keep flowing while a result works its way down that pipeline.
// A result held at the output with out_ready low stalls the pipeline and drops in_ready.
// arst_n clears the term, scale, sums, error flag and all valid bits.
module time_expression_parser_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           char_code,
	input  logic                                 end_of_text,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [tep_pkg::SEC_W-1:0]     seconds,
	output logic        [tep_pkg::TICK_W-1:0]    coarse_ticks,
	output logic        [tep_pkg::FRAC_W-1:0]    fraction,
	output logic                                 parse_error
);

	typedef enum logic [2:0] {
		SCALE_PS = 3'd0,
		SCALE_NS = 3'd1,
		SCALE_US = 3'd2,
		SCALE_MS = 3'd3,
		SCALE_S  = 3'd4
	} scale_t;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_P     = 8'h70;

	logic [63:0]        term_q;
	logic               neg_q;
	scale_t             scale_q;
	logic               err_q;
	tep_pkg::sums_t     sum_q;

	logic               accept;
	logic               adv;
	logic               norm_vld;
	logic               is_digit;
	logic [63:0]        term_x10;
	logic [63:0]        addend;
	logic [63:0]        fold_base;
	logic [63:0]        fold_val;
	tep_pkg::sums_t     sum_fold;
	tep_pkg::norm_ctl_t ctl;

	assign adv      = ~norm_vld | out_ready;
	assign in_ready = adv;
	assign accept   = in_valid & in_ready;

	assign is_digit = (char_code >= CH_0) && (char_code <= CH_9);
	assign term_x10 = {term_q[60:0], 3'd0} + {term_q[62:0], 1'b0} + {60'd0, char_code[3:0]};

	// signed fold as one add: subtract by inverted term with carry in
	assign addend = neg_q ? ~term_q : term_q;

	always_comb begin
		unique case (scale_q)
			SCALE_S:  fold_base = sum_q.sec;
			SCALE_MS: fold_base = sum_q.ms;
			SCALE_US: fold_base = sum_q.us;
			SCALE_NS: fold_base = sum_q.ns;
			default:  fold_base = sum_q.ps;
		endcase
		fold_val = fold_base + addend + {63'd0, neg_q};
		sum_fold = sum_q;
		unique case (scale_q)
			SCALE_S:  sum_fold.sec = fold_val;
			SCALE_MS: sum_fold.ms  = fold_val;
			SCALE_US: sum_fold.us  = fold_val;
			SCALE_NS: sum_fold.ns  = fold_val;
			default:  sum_fold.ps  = fold_val;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q  <= '0;
			neg_q   <= 1'b0;
			scale_q <= SCALE_PS;
			err_q   <= 1'b0;
			sum_q   <= '0;
		end else if (accept) begin
			if (end_of_text) begin
				term_q  <= '0;
				neg_q   <= 1'b0;
				scale_q <= SCALE_PS;
				err_q   <= 1'b0;
				sum_q   <= '0;
			end else if (!err_q) begin
				priority if (is_digit) begin
					term_q <= term_x10;
				end else if (char_code == CH_PLUS || char_code == CH_MINUS) begin
					sum_q  <= sum_fold;
					term_q <= '0;
					neg_q  <= (char_code == CH_MINUS);
				end else if (char_code == CH_S) begin
					scale_q <= SCALE_S;
				end else if (char_code == CH_M) begin
					scale_q <= SCALE_MS;
				end else if (char_code == CH_U) begin
					scale_q <= SCALE_US;
				end else if (char_code == CH_N) begin
					scale_q <= SCALE_NS;
				end else if (char_code == CH_P) begin
					scale_q <= SCALE_PS;
				end else begin
					err_q <= 1'b1;
				end
			end
		end
	end

	// an errored expression enters with zero sums so every time field comes out zero
	assign ctl.adv  = adv;
	assign ctl.load = accept & end_of_text;
	assign ctl.err  = err_q;

	tep_norm u_norm (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sums         (err_q ? '0 : sum_fold),
		.vld          (norm_vld),
		.seconds      (seconds),
		.coarse_ticks (coarse_ticks),
		.fraction     (fraction),
		.parse_error  (parse_error)
	);

	assign out_valid = norm_vld;

endmodule

### design/tep_norm.sv
module tep_norm (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tep_pkg::norm_ctl_t                   ctl,
	input  tep_pkg::sums_t                       sums,
	output logic                                 vld,
	output logic signed [tep_pkg::SEC_W-1:0]     seconds,
	output logic        [tep_pkg::TICK_W-1:0]    coarse_ticks,
	output logic        [tep_pkg::FRAC_W-1:0]    fraction,
	output logic                                 parse_error
);

	localparam int NSTG = 13;

	localparam logic [41:0] C_NS    = 42'd1000;
	localparam logic [51:0] C_US    = 52'd1000000;
	localparam logic [61:0] C_MS    = 62'd1000000000;
	// 1e12 = 4096 * 5^12; quotient estimate uses floor(2^66 / 1e12)
	localparam logic [27:0] DIV_SEC = 28'd244140625;
	localparam logic [26:0] RCP_SEC = 27'd73786976;
	localparam logic [39:0] PS_SEC  = 40'd1000000000000;
	// ticks: (ps >> 6) / 125, estimate with floor(2^38 / 125)
	localparam logic [31:0] RCP_TK  = 32'd2199023255;
	localparam logic [7:0]  DIV_TK  = 8'd125;
	// fraction: floor(rem * 64 / 125) = (rem * ceil(2^26 / 125)) >> 20
	localparam logic [19:0] RCP_FR  = 20'd536871;

	logic [NSTG-1:0] stg_vld_q;
	logic [NSTG-1:0] stg_err_q;

	// s1
	tep_pkg::sums_t sums_s1;
	// s2
	logic [63:0] ps_s2, sec_s2;
	logic [41:0] nlo_s2;
	logic [51:0] ulo_s2;
	logic [61:0] mlo_s2;
	logic [31:0] nhi_s2, uhi_s2, mhi_s2;
	// s3, s4
	logic [63:0] a_s3, b_s3, sec_s3;
	logic [63:0] pico_s4, sec_s4;
	// s5 .. s8
	logic [63:0] mag_s5, sec_s5;
	logic        neg_s5;
	logic [23:0] qe_s6;
	logic [41:0] mlow_s6;
	logic [63:0] sec_s6;
	logic        neg_s6;
	logic [29:0] r1_s7;
	logic [23:0] qe_s7;
	logic [11:0] lo12_s7;
	logic [63:0] sec_s7;
	logic        neg_s7;
	logic [23:0] q_s8;
	logic [39:0] rps_s8;
	logic [63:0] sec_s8;
	logic        neg_s8;
	// s9 .. s13
	logic [39:0] ps_s9;
	logic [25:0] delta_s9;
	logic [63:0] sec_s9;
	logic [64:0] secsum_s10;
	logic [39:0] ps_s10;
	logic [26:0] est_s10;
	logic [40:0] secs_s11;
	logic [7:0]  r2_s11;
	logic [26:0] est_s11;
	logic [5:0]  lo6_s11;
	logic [40:0] secs_s12;
	logic [26:0] ticks_s12;
	logic [12:0] rem_s12;
	logic [40:0] secs_s13;
	logic [26:0] ticks_s13;
	logic [11:0] frac_s13;

	logic [63:0] mag_d;
	logic [54:0] qprod_d;
	logic [51:0] dprod_d;
	logic [23:0] kq_d;
	logic        nz_d;
	logic [63:0] tprod_d;
	logic [7:0]  tlow_d;
	logic [32:0] fprod_d;
	logic [29:0] r1_sub_d;
	logic [7:0]  r2_sub_d;

	always_comb begin
		mag_d    = pico_s4[63] ? (64'd0 - pico_s4) : pico_s4;
		qprod_d  = 55'(mag_s5[63:36]) * 55'(RCP_SEC);
		dprod_d  = 52'(qe_s6) * 52'(DIV_SEC);
		r1_sub_d = r1_s7 - 30'(DIV_SEC);
		nz_d     = |rps_s8;
		kq_d     = q_s8 + 24'(nz_d);
		tprod_d  = 64'(ps_s9[39:8]) * 64'(RCP_TK);
		tlow_d   = 8'(est_s10 * 27'(DIV_TK));
		r2_sub_d = r2_s11 - DIV_TK;
		fprod_d  = 33'(rem_s12) * 33'(RCP_FR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
		end else if (ctl.adv) begin
			stg_vld_q <= {stg_vld_q[NSTG-2:0], ctl.load};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			stg_err_q <= {stg_err_q[NSTG-2:0], ctl.err};

			sums_s1 <= sums;

			ps_s2  <= sums_s1.ps;
			sec_s2 <= sums_s1.sec;
			nlo_s2 <= {10'd0, sums_s1.ns[31:0]} * C_NS;
			ulo_s2 <= {20'd0, sums_s1.us[31:0]} * C_US;
			mlo_s2 <= {30'd0, sums_s1.ms[31:0]} * C_MS;
			nhi_s2 <= sums_s1.ns[63:32] * 32'(C_NS);
			uhi_s2 <= sums_s1.us[63:32] * 32'(C_US);
			mhi_s2 <= sums_s1.ms[63:32] * 32'(C_MS);

			a_s3   <= ps_s2 + 64'(nlo_s2) + {nhi_s2, 32'd0};
			b_s3   <= 64'(ulo_s2) + {uhi_s2, 32'd0} + 64'(mlo_s2) + {mhi_s2, 32'd0};
			sec_s3 <= sec_s2;

			pico_s4 <= a_s3 + b_s3;
			sec_s4  <= sec_s3;

			neg_s5 <= pico_s4[63];
			mag_s5 <= mag_d;
			sec_s5 <= sec_s4;

			qe_s6   <= qprod_d[53:30];
			mlow_s6 <= mag_s5[41:0];
			neg_s6  <= neg_s5;
			sec_s6  <= sec_s5;

			// true remainder is below twice the divisor, so 30 bits are enough
			r1_s7   <= mlow_s6[41:12] - dprod_d[29:0];
			qe_s7   <= qe_s6;
			lo12_s7 <= mlow_s6[11:0];
			neg_s7  <= neg_s6;
			sec_s7  <= sec_s6;

			if (r1_s7 >= 30'(DIV_SEC)) begin
				q_s8   <= qe_s7 + 24'd1;
				rps_s8 <= {r1_sub_d[27:0], lo12_s7};
			end else begin
				q_s8   <= qe_s7;
				rps_s8 <= {r1_s7[27:0], lo12_s7};
			end
			neg_s8 <= neg_s7;
			sec_s8 <= sec_s7;

			// negative sum: borrow whole seconds, rounding the magnitude up
			if (neg_s8) begin
				ps_s9    <= nz_d ? (PS_SEC - rps_s8) : 40'd0;
				delta_s9 <= 26'd0 - 26'(kq_d);
			end else begin
				ps_s9    <= rps_s8;
				delta_s9 <= 26'(q_s8);
			end
			sec_s9 <= sec_s8;

			secsum_s10 <= {sec_s9[63], sec_s9} + {{39{delta_s9[25]}}, delta_s9};
			ps_s10     <= ps_s9;
			est_s10    <= tprod_d[62:36];

			if (secsum_s10[64:40] == {25{secsum_s10[64]}}) begin
				secs_s11 <= secsum_s10[40:0];
			end else if (secsum_s10[64]) begin
				secs_s11 <= {1'b1, 40'd0};
			end else begin
				secs_s11 <= {1'b0, {40{1'b1}}};
			end
			r2_s11  <= ps_s10[13:6] - tlow_d;
			est_s11 <= est_s10;
			lo6_s11 <= ps_s10[5:0];

			if (r2_s11 >= DIV_TK) begin
				ticks_s12 <= est_s11 + 27'd1;
				rem_s12   <= {r2_sub_d[6:0], lo6_s11};
			end else begin
				ticks_s12 <= est_s11;
				rem_s12   <= {r2_s11[6:0], lo6_s11};
			end
			secs_s12 <= secs_s11;

			secs_s13  <= secs_s12;
			ticks_s13 <= ticks_s12;
			frac_s13  <= fprod_d[31:20];
		end
	end

	assign vld          = stg_vld_q[NSTG-1];
	assign parse_error  = stg_err_q[NSTG-1];
	assign seconds      = $signed(secs_s13);
	assign coarse_ticks = ticks_s13;
	assign fraction     = frac_s13;

endmodule

### tb/tep_time_check.sv
`timescale 1ns / 100ps

module tep_time_check (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic [7:0]                       char_code,
	input  logic                             end_of_text,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic signed [tep_pkg::SEC_W-1:0] seconds,
	input  logic [tep_pkg::TICK_W-1:0]       coarse_ticks,
	input  logic [tep_pkg::FRAC_W-1:0]       fraction,
	input  logic                             parse_error,
	output int                               results_due,
	output int                               mismatch_count
);

	typedef enum logic [2:0] {
		SCALE_PS,
		SCALE_NS,
		SCALE_US,
		SCALE_MS,
		SCALE_S
	} scale_t;

	typedef struct {
		logic signed [tep_pkg::SEC_W-1:0] seconds;
		logic [tep_pkg::TICK_W-1:0]       ticks;
		logic [tep_pkg::FRAC_W-1:0]       frac;
		logic                             err;
	} parsed_time_t;

	localparam logic [63:0] PS_PER_SEC  = 64'd1_000_000_000_000;
	localparam logic [63:0] PS_PER_TICK = 64'd8000;
	localparam logic [63:0] FRAC_STEPS  = 64'd4096;
	localparam longint      SEC_HI      = (longint'(1) <<< (tep_pkg::SEC_W - 1)) - 1;
	localparam longint      SEC_LO      = -(longint'(1) <<< (tep_pkg::SEC_W - 1));
	localparam longint      WIDE_CLAMP  = longint'(1) <<< 62;

	logic [63:0]  term;
	logic [63:0]  ps_acc;
	logic [63:0]  sec_acc;
	logic         term_neg;
	logic         err_seen;
	scale_t       scale;
	int           misses;
	parsed_time_t expected_times[$];

	function automatic void clear_parse_state();
		term     = '0;
		term_neg = 1'b0;
		scale    = SCALE_PS;
		ps_acc   = '0;
		sec_acc  = '0;
		err_seen = 1'b0;
	endfunction

	// all term and sum arithmetic wraps at 64 bits
	function automatic void fold_term();
		logic [63:0] v;
		v = term_neg ? -term : term;
		case (scale)
			SCALE_S:  sec_acc += v;
			SCALE_MS: ps_acc  += v * 64'd1_000_000_000;
			SCALE_US: ps_acc  += v * 64'd1_000_000;
			SCALE_NS: ps_acc  += v * 64'd1000;
			default:  ps_acc  += v;
		endcase
		term = '0;
	endfunction

	function automatic parsed_time_t close_expression();
		parsed_time_t r;
		logic [63:0]  ps;
		logic [63:0]  mag;
		logic [63:0]  k;
		logic [63:0]  ticks64;
		logic [63:0]  frac64;
		longint       secs;
		longint       carry;
		r.seconds = '0;
		r.ticks   = '0;
		r.frac    = '0;
		r.err     = err_seen;
		if (!err_seen) begin
			fold_term();
			ps = ps_acc;
			if (ps[63]) begin
				// negative picoseconds: borrow whole seconds
				mag   = -ps;
				k     = (mag + PS_PER_SEC - 64'd1) / PS_PER_SEC;
				ps    = k * PS_PER_SEC - mag;
				carry = -longint'(k);
			end else begin
				carry = longint'(ps / PS_PER_SEC);
				ps    = ps % PS_PER_SEC;
			end
			secs = longint'(sec_acc);
			if (secs > WIDE_CLAMP)
				secs = WIDE_CLAMP;
			if (secs < -WIDE_CLAMP)
				secs = -WIDE_CLAMP;
			secs += carry;
			if (secs > SEC_HI)
				secs = SEC_HI;
			if (secs < SEC_LO)
				secs = SEC_LO;
			ticks64   = ps / PS_PER_TICK;
			frac64    = (ps % PS_PER_TICK) * FRAC_STEPS / PS_PER_TICK;
			r.seconds = secs[tep_pkg::SEC_W-1:0];
			r.ticks   = ticks64[tep_pkg::TICK_W-1:0];
			r.frac    = frac64[tep_pkg::FRAC_W-1:0];
		end
		clear_parse_state();
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		parsed_time_t want;
		if (!arst_n) begin
			clear_parse_state();
			expected_times.delete();
			misses = 0;
			results_due <= 0;
			mismatch_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_times.size() == 0) begin
					misses++;
					if (misses <= 10)
						$display("%0t: unexpected result: %0d %0d %0d %0b",
							$realtime, seconds, coarse_ticks, fraction, parse_error);
				end else begin
					want = expected_times.pop_front();
					if (want.seconds !== seconds || want.ticks !== coarse_ticks ||
							want.frac !== fraction || want.err !== parse_error) begin
						misses++;
						if (misses <= 10)
							$display("%0t: mismatch: want %0d %0d %0d %0b, got %0d %0d %0d %0b",
								$realtime, want.seconds, want.ticks, want.frac, want.err,
								seconds, coarse_ticks, fraction, parse_error);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (end_of_text) begin
					expected_times.push_back(close_expression());
				end else if (!err_seen) begin
					if (char_code >= "0" && char_code <= "9") begin
						term = term * 64'd10 + 64'(char_code - "0");
					end else begin
						case (char_code)
							"+", "-": begin
								fold_term();
								term_neg = (char_code == "-");
							end
							"s": scale = SCALE_S;
							"m": scale = SCALE_MS;
							"u": scale = SCALE_US;
							"n": scale = SCALE_NS;
							"p": scale = SCALE_PS;
							default: err_seen = 1'b1;
						endcase
					end
				end
			end
			results_due <= expected_times.size();
			mismatch_count <= misses;
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_CHARS = 1000;

	logic                             clk;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_ready;
	logic [7:0]                       char_code;
	logic                             end_of_text;
	logic                             out_valid;
	logic                             out_ready;
	logic signed [tep_pkg::SEC_W-1:0] seconds;
	logic [tep_pkg::TICK_W-1:0]       coarse_ticks;
	logic [tep_pkg::FRAC_W-1:0]       fraction;
	logic                             parse_error;
	int                               results_due;
	int                               mismatch_count;
	int                               idle_cycles = 0;
	int                               chars_sent = 0;
	bit                               in_quiet = 1'b0;
	bit                               out_quiet = 1'b0;

	time_expression_parser_core dut (.*);

	tep_time_check u_time_check (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int draw_wait(bit quiet);
		return quiet ? 0 : $urandom_range(0, 7);
	endfunction

	task automatic send_char(input logic [7:0] code, input logic last);
		int gap;
		if ($urandom_range(0, 63) == 0)
			in_quiet = !in_quiet;
		gap = draw_wait(in_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		char_code   <= code;
		end_of_text <= last;
		do @(posedge clk); while (!in_ready);
		chars_sent++;
	endtask

	task automatic send_text(input string text, input logic [7:0] close_code);
		for (int i = 0; i < text.len(); i++)
			send_char(text[i], 1'b0);
		send_char(close_code, 1'b1);
	endtask

	// mostly well-formed terms, some very long ones, the odd stray byte
	task automatic send_random_expression();
		string letters;
		int    terms;
		int    ndig;
		bit    wide;
		letters = "smunp";
		terms = $urandom_range(0, 4);
		for (int t = 0; t < terms; t++) begin
			if (t > 0 || $urandom_range(0, 3) == 0)
				send_char($urandom_range(0, 1) ? "-" : "+", 1'b0);
			wide = ($urandom_range(0, 7) == 0);
			if (wide && $urandom_range(0, 1))
				send_char("s", 1'b0);
			else if ($urandom_range(0, 1))
				send_char(letters[$urandom_range(0, 4)], 1'b0);
			ndig = wide ? $urandom_range(13, 22) : $urandom_range(1, 6);
			repeat (ndig)
				send_char(8'("0" + $urandom_range(0, 9)), 1'b0);
			if ($urandom_range(0, 2) == 0)
				send_char(letters[$urandom_range(0, 4)], 1'b0);
			if ($urandom_range(0, 15) == 0)
				send_char(8'($urandom_range(0, 255)), 1'b0);
		end
		send_char(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic wait_results_in();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
	endtask

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		char_code   <= '0;
		end_of_text <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// empty expression, with the ignored code at its top value
		send_char(8'hFF, 1'b1);
		send_text("1234567890n-9p", 8'h00);
		// negative picosecond sum borrows from the seconds
		send_text("-4u+2s-3m", 8'hA5);
		// zero byte is invalid, the digit after it is ignored
		send_char(8'h00, 1'b0);
		send_text("7", 8'h5A);

		wait_results_in();
		while (chars_sent < RANDOM_CHARS / 2)
			send_random_expression();
		wait_results_in();
		while (chars_sent < RANDOM_CHARS)
			send_random_expression();

		wait_results_in();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_due == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int gap;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 63) == 0)
				out_quiet = !out_quiet;
			gap = draw_wait(out_quiet);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// counts cycles in which no item moves on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
